### sv/usbf_pkg.sv
// Shared types, constants and command/status structs for the URL seen bitmap filter.
package usbf_pkg;

    localparam int TABLE_BITS = 1048576;
    localparam int IDX_W      = $clog2(TABLE_BITS);
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int ROWS       = TABLE_BITS / WORD_W;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BIDX_W     = 20;

    localparam int HASH_MUL = 31;
    localparam int DOC_MUL  = 23;

    localparam logic [7:0] CHAR_LOW  = 8'h41;
    localparam logic [7:0] CHAR_HIGH = 8'h7A;

    localparam logic [1:0] MODE_TEST = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_TSET = 2'd2;
    localparam logic [1:0] MODE_DOC  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic       first;
        logic [15:0] port;
        logic       char_valid;
        logic [7:0] char_byte;
        logic       last;
    } req_t;

    typedef struct packed {
        logic              already_seen;
        logic [BIDX_W-1:0] bit_index;
    } rsp_t;

    typedef struct packed {
        logic hash_load;
        logic rd_en;
        logic commit;
        logic clr_en;
    } cmd_t;

    typedef struct packed {
        logic item_last;
        logic clr_last;
    } status_t;

endpackage

### sv/usbf_ram.sv
// Generic single-port RAM with registered read data.
module usbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     wr_en,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

### sv/usbf_datapath.sv
// Datapath: key hash accumulator, bitmap RAM, clearing counter and result register.
module usbf_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  usbf_pkg::cmd_t    cmd,
    output usbf_pkg::status_t status,
    input  usbf_pkg::req_t    req,
    output usbf_pkg::rsp_t    rsp
);
    import usbf_pkg::*;

    logic [31:0]      hash_reg, hash_next;
    logic [1:0]       mode_reg, mode_next;
    logic [ROW_W-1:0] clr_cnt_reg, clr_cnt_next;
    rsp_t             rsp_reg, rsp_next;

    logic [31:0]       seed;
    logic [31:0]       url_sum;
    logic [IDX_W+4:0]  doc_sum;
    logic [31:0]       folded;
    logic [IDX_W-1:0]  idx;
    logic [ROW_W-1:0]  ram_addr;
    logic              ram_wr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] bit_mask;

    always_comb
    begin
        mode_next = req.first ? req.req_type : mode_reg;
        if (req.first)
        begin
            seed = (req.req_type == MODE_DOC) ? 32'd0 : {16'd0, req.port};
        end
        else
        begin
            seed = hash_reg;
        end
        url_sum = seed * 32'(HASH_MUL) + {{24{req.char_byte[7]}}, req.char_byte};
        doc_sum = (IDX_W+5)'(seed[IDX_W-1:0]) * (IDX_W+5)'(DOC_MUL)
                + (IDX_W+5)'(req.char_byte);
        folded = seed;
        if (req.char_valid)
        begin
            if (mode_next != MODE_DOC)
            begin
                folded = url_sum;
            end
            else if (req.char_byte > CHAR_LOW && req.char_byte < CHAR_HIGH)
            begin
                folded = 32'(doc_sum[IDX_W-1:0]);
            end
        end
        hash_next = cmd.hash_load ? folded : hash_reg;
        if (!cmd.hash_load)
        begin
            mode_next = mode_reg;
        end
    end

    assign idx      = hash_reg[IDX_W-1:0];
    assign bit_mask = WORD_W'(1) << idx[BIT_W-1:0];

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_en)
        begin
            clr_cnt_next = clr_cnt_reg + ROW_W'(1);
        end
        ram_addr  = cmd.clr_en ? clr_cnt_reg : idx[IDX_W-1:BIT_W];
        ram_wr    = cmd.clr_en || (cmd.commit && mode_reg != MODE_TEST);
        ram_wdata = cmd.clr_en ? '0 : (ram_rdata | bit_mask);
        rsp_next  = rsp_reg;
        if (cmd.commit)
        begin
            rsp_next.already_seen = ram_rdata[idx[BIT_W-1:0]];
            rsp_next.bit_index    = BIDX_W'(idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg    <= '0;
            mode_reg    <= MODE_TEST;
            clr_cnt_reg <= '0;
        end
        else
        begin
            hash_reg    <= hash_next;
            mode_reg    <= mode_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    usbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .clk     (clk),
        .addr    (ram_addr),
        .wr_en   (ram_wr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_data (ram_rdata)
    );

    assign status.item_last = req.last;
    assign status.clr_last  = (clr_cnt_reg == ROW_W'(ROWS - 1));
    assign rsp              = rsp_reg;

endmodule

### sv/usbf_ctrl.sv
// Controller state machine: clearing pass, key intake, bitmap read and update, result handoff.
module usbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  usbf_pkg::status_t status,
    output usbf_pkg::cmd_t    cmd
);
    import usbf_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_RUN);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (req_valid)
                begin
                    cmd.hash_load = 1'b1;
                    if (status.item_last)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### sv/url_seen_bitmap_filter.sv
// Top level of the URL seen bitmap filter: single-hash bitmap test and set over streamed keys.
// A key byte that is not last is folded into the hash; the next item is accepted in the following cycle.
// After a last byte the hash is folded, the bitmap row is read and the row is updated, in that order,
// over the single RAM port; its result is loaded into the output register with the row update, which is
// held back while an earlier result still waits there.
// After reset the bitmap is cleared one 32-bit row per cycle, all 32768 rows, while req_ready is low.
module url_seen_bitmap_filter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  usbf_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output usbf_pkg::rsp_t rsp
);
    import usbf_pkg::*;

    cmd_t    cmd;
    status_t status;

    usbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    usbf_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule
